/* rtl/dtrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrp_pkg
// Types and constants shared by the drive-to-relative-point controller.
// ----------------------------------------------------------------------------
package dtrp_pkg;

    localparam int MAG_W   = 31;
    localparam int SPEED_W = 15;
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int NUM_W   = MAG_W + SPEED_W;
    localparam int QUOT_W  = 16;
    localparam int OUT_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 32;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_TICK   = 2'd2
    } t_action;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_REACHED = 2'd1;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

    localparam logic [CIDX_W-1:0] REG_OFFSET_X   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TGT_HDG    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SPEED      = 3'd3;
    localparam logic [CIDX_W-1:0] REG_THRESHOLD  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_TIMEOUT    = 3'd5;
    localparam logic [CIDX_W-1:0] REG_STOP       = 3'd6;

endpackage

/* rtl/dtrp_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrp_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module dtrp_sqrt import dtrp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  cand;
    logic              ge;

    assign trial = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign cand  = {2'b00, r_root, 2'b01};
    assign ge    = (trial >= cand);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ROOT_W);
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? REM_W'(trial - cand) : REM_W'(trial);
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

/* rtl/dtrp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrp_div
// Bit-serial restoring divider for the translation command, one quotient
// bit per cycle. The quotient is known to fit in sixteen bits.
// ----------------------------------------------------------------------------
module dtrp_div import dtrp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic              o_busy,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [ROOT_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_den;
    logic [QUOT_W-1:0] r_lo;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [ROOT_W:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_lo[QUOT_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUOT_W);
            r_rem  <= ROOT_W'(i_num[NUM_W-1:QUOT_W]);
            r_lo   <= i_num[QUOT_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? ROOT_W'(trial - {1'b0, r_den}) : ROOT_W'(trial);
            r_lo   <= {r_lo[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* rtl/dtrp_rot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtrp_rot
// Rotation command: heading error scaled by 0.05 per degree and clamped to
// 0.75, using a bit-serial divide by five.
// ----------------------------------------------------------------------------
module dtrp_rot import dtrp_pkg::*; #(
    parameter int VEL_FRAC_BITS = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_err_mag,
    input  logic             i_err_neg,
    output logic             o_busy,
    output logic [OUT_W-1:0] o_vel_rot
);

    // The error in 1/256 degree times 0.05 equals the error times 2^F / 5120.
    localparam int NW    = 12 + VEL_FRAC_BITS;
    localparam int VW    = VEL_FRAC_BITS + 2;
    localparam int CNT_W = $clog2(NW + 1);
    localparam logic [VW-1:0] RMAX = VW'(3) << (VEL_FRAC_BITS - 2);

    logic [NW-1:0]    r_num;
    logic [NW-1:0]    r_quo;
    logic [2:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_big;
    logic             r_neg;

    logic [3:0]       trial;
    logic             ge;
    logic [VW-1:0]    vr;
    logic [VW-1:0]    mag;
    logic [31:0]      mag32;
    logic [31:0]      sgn32;

    assign trial = {r_rem, r_num[NW-1]};
    assign ge    = (trial >= 4'd5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NW);
            r_num  <= {i_err_mag[11:0], {VEL_FRAC_BITS{1'b0}}};
            r_quo  <= '0;
            r_rem  <= '0;
            r_big  <= (i_err_mag[31:12] != '0);
            r_neg  <= i_err_neg;
        end else if (r_busy) begin
            r_rem <= ge ? 3'(trial - 4'd5) : 3'(trial);
            r_quo <= {r_quo[NW-2:0], ge};
            r_num <= {r_num[NW-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign vr    = r_quo[NW-1:10];
    assign mag   = (r_big || (vr > RMAX)) ? RMAX : vr;
    assign mag32 = 32'(mag);
    assign sgn32 = r_neg ? (32'd0 - mag32) : mag32;

    assign o_busy    = r_busy;
    assign o_vel_rot = sgn32[OUT_W-1:0];

endmodule

/* rtl/drive_to_relative_point.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_to_relative_point
// Drives toward a goal latched at start as position plus offset. Each update
// gives a translation command along the goal vector and a clamped rotation
// command toward the target heading; ticks run an optional timeout.
//
//   Channel   Signals                                   Direction
//   input     i_in_valid / o_in_ready, action, pos, yaw  in
//   result    o_out_valid / i_out_ready, vel, finish     out
//   config    i_cfg_we, i_cfg_idx, i_cfg_wdata           in
//
// Start, tick and ignored items go from S_EXEC to S_PUT, which raises the
// result valid once the output register is free. An update first shifts
// both deltas right once per bit that the larger goal delta has beyond 31
// bits, then runs the serial root (one bit per cycle) and two serial divides
// (one quotient bit per cycle); at zero distance the divides are skipped.
// Reset is synchronous and clears the goal, the latches and the tick count.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module drive_to_relative_point import dtrp_pkg::*; #(
    parameter int POS_WIDTH     = 32,
    parameter int VEL_FRAC_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CIDX_W-1:0]    i_cfg_idx,
    input  logic [CDAT_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic [POS_WIDTH-1:0] i_pos_x,
    input  logic [POS_WIDTH-1:0] i_pos_y,
    input  logic [31:0]          i_yaw,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_W-1:0]     o_vel_x,
    output logic [OUT_W-1:0]     o_vel_y,
    output logic [OUT_W-1:0]     o_vel_rot,
    output logic                 o_finished,
    output logic [1:0]           o_finish_cause,
    output logic                 o_stop_drive
);

    localparam int SW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;
    localparam int DW = POS_WIDTH + 1;
    localparam int MW = (DW > 32) ? DW : 32;
    localparam logic [SW-1:0] PMAX = SW'({(POS_WIDTH-1){1'b1}});
    localparam logic [SW-1:0] PMIN = ~PMAX;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_NORM, S_SQX, S_SQY, S_ROOT_GO, S_ROOT_WAIT,
        S_MULX, S_DIVX, S_MULY, S_DIVY, S_FIN, S_PUT
    } t_state;

    t_state r_state;

    logic [31:0]          r_off_x, r_off_y, r_tgt_hdg;
    logic [SPEED_W-1:0]   r_speed;
    logic [15:0]          r_thresh;
    logic [23:0]          r_tmo;
    logic                 r_stop;

    logic [POS_WIDTH-1:0] r_goal_x, r_goal_y;
    logic                 r_reached, r_running;
    logic [23:0]          r_ticks;

    logic [1:0]           r_act;
    logic [POS_WIDTH-1:0] r_px, r_py;
    logic [31:0]          r_yaw;

    logic [MW-1:0]        r_ax, r_ay;
    logic                 r_dx_neg, r_dy_neg, r_shifted;
    logic [RAD_W-1:0]     r_sum, r_sq;
    logic [ROOT_W-1:0]    r_root;
    logic [NUM_W-1:0]     r_prod;
    logic                 r_div_go;

    logic [OUT_W-1:0]     r_vx, r_vy;
    logic                 r_fin, r_sdrv;
    logic [1:0]           r_cause;

    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_o_vx, r_o_vy, r_o_vrot;
    logic                 r_o_fin, r_o_sdrv;
    logic [1:0]           r_o_cause;

    logic [SW-1:0]        sum_x, sum_y;
    logic [DW-1:0]        dx, dy, ax_d, ay_d;
    logic [32:0]          err, err_mag;
    logic [23:0]          n_ticks;
    logic [MAG_W-1:0]     ax31, ay31, mul_a, mul_b;
    logic [2*MAG_W-1:0]   mul_p;
    logic                 sqrt_start, sqrt_busy, div_busy, rot_start, rot_busy;
    logic [ROOT_W-1:0]    root;
    logic [QUOT_W-1:0]    quot;
    logic [OUT_W-1:0]     vel_rot, q_neg;
    logic                 wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_tgt_hdg <= '0;
            r_speed   <= '0;
            r_thresh  <= 16'd256;
            r_tmo     <= '0;
            r_stop    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OFFSET_X:  r_off_x   <= i_cfg_wdata;
                REG_OFFSET_Y:  r_off_y   <= i_cfg_wdata;
                REG_TGT_HDG:   r_tgt_hdg <= i_cfg_wdata;
                REG_SPEED:     r_speed   <= i_cfg_wdata[SPEED_W-1:0];
                REG_THRESHOLD: r_thresh  <= i_cfg_wdata[15:0];
                REG_TIMEOUT:   r_tmo     <= i_cfg_wdata[23:0];
                REG_STOP:      r_stop    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign sum_x = SW'($signed(r_px)) + SW'($signed(r_off_x));
    assign sum_y = SW'($signed(r_py)) + SW'($signed(r_off_y));
    assign dx    = DW'($signed(r_goal_x)) - DW'($signed(r_px));
    assign dy    = DW'($signed(r_goal_y)) - DW'($signed(r_py));
    assign ax_d  = dx[DW-1] ? (DW'(0) - dx) : dx;
    assign ay_d  = dy[DW-1] ? (DW'(0) - dy) : dy;
    assign err   = 33'($signed(r_tgt_hdg)) - 33'($signed(r_yaw));
    assign err_mag = err[32] ? (33'd0 - err) : err;
    assign n_ticks = (r_ticks != '1) ? (r_ticks + 24'd1) : r_ticks;

    assign ax31 = r_ax[MAG_W-1:0];
    assign ay31 = r_ay[MAG_W-1:0];
    assign wide = ((r_ax | r_ay) >> MAG_W) != '0;

    always_comb begin
        mul_a = ax31;
        mul_b = ax31;
        case (r_state)
            S_SQY:  begin mul_a = ay31; mul_b = ay31; end
            S_MULX: begin mul_a = ax31; mul_b = MAG_W'(r_speed); end
            S_MULY: begin mul_a = ay31; mul_b = MAG_W'(r_speed); end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign sqrt_start = (r_state == S_ROOT_GO);
    assign rot_start  = (r_state == S_EXEC) && (r_act == ACT_UPDATE) && r_running;
    assign q_neg      = OUT_W'(0) - quot;

    dtrp_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_sum + r_sq),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    dtrp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_prod),
        .i_den   (r_root),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    dtrp_rot #(
        .VEL_FRAC_BITS (VEL_FRAC_BITS)
    ) u_rot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rot_start),
        .i_err_mag (err_mag[31:0]),
        .i_err_neg (err[32]),
        .o_busy    (rot_busy),
        .o_vel_rot (vel_rot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_reached   <= 1'b0;
            r_running   <= 1'b0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act   <= i_action;
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_yaw   <= i_yaw;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_vx    <= '0;
                    r_vy    <= '0;
                    r_fin   <= 1'b0;
                    r_cause <= CAUSE_NONE;
                    r_sdrv  <= 1'b0;
                    r_state <= S_PUT;
                    case (r_act)
                        ACT_START: begin
                            if ($signed(sum_x) > $signed(PMAX)) begin
                                r_goal_x <= PMAX[POS_WIDTH-1:0];
                            end else if ($signed(sum_x) < $signed(PMIN)) begin
                                r_goal_x <= PMIN[POS_WIDTH-1:0];
                            end else begin
                                r_goal_x <= sum_x[POS_WIDTH-1:0];
                            end
                            if ($signed(sum_y) > $signed(PMAX)) begin
                                r_goal_y <= PMAX[POS_WIDTH-1:0];
                            end else if ($signed(sum_y) < $signed(PMIN)) begin
                                r_goal_y <= PMIN[POS_WIDTH-1:0];
                            end else begin
                                r_goal_y <= sum_y[POS_WIDTH-1:0];
                            end
                            r_reached <= 1'b0;
                            r_ticks   <= '0;
                            r_running <= 1'b1;
                        end
                        ACT_UPDATE: begin
                            if (r_running) begin
                                r_ax      <= MW'(ax_d);
                                r_ay      <= MW'(ay_d);
                                r_dx_neg  <= dx[DW-1];
                                r_dy_neg  <= dy[DW-1];
                                r_shifted <= 1'b0;
                                r_state   <= S_NORM;
                            end
                        end
                        ACT_TICK: begin
                            if (r_running) begin
                                r_ticks <= n_ticks;
                                if ((r_tmo != '0) && (n_ticks >= r_tmo)) begin
                                    r_fin     <= 1'b1;
                                    r_cause   <= CAUSE_TIMEOUT;
                                    r_sdrv    <= r_stop;
                                    r_running <= 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_NORM: begin
                    if (wide) begin
                        r_ax      <= r_ax >> 1;
                        r_ay      <= r_ay >> 1;
                        r_shifted <= 1'b1;
                    end else begin
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_sum   <= RAD_W'(mul_p);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sq    <= RAD_W'(mul_p);
                    r_state <= S_ROOT_GO;
                end
                S_ROOT_GO: begin
                    r_state <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT: begin
                    if (!sqrt_busy) begin
                        r_root  <= root;
                        r_state <= (root == '0) ? S_FIN : S_MULX;
                    end
                end
                S_MULX: begin
                    r_prod   <= mul_p[NUM_W-1:0];
                    r_div_go <= 1'b1;
                    r_state  <= S_DIVX;
                end
                S_DIVX: begin
                    if (!r_div_go && !div_busy) begin
                        r_vx    <= r_dx_neg ? q_neg : quot;
                        r_state <= S_MULY;
                    end
                end
                S_MULY: begin
                    r_prod   <= mul_p[NUM_W-1:0];
                    r_div_go <= 1'b1;
                    r_state  <= S_DIVY;
                end
                S_DIVY: begin
                    if (!r_div_go && !div_busy) begin
                        r_vy    <= r_dy_neg ? q_neg : quot;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!rot_busy) begin
                        if (r_reached || (!r_shifted && (r_root <= ROOT_W'(r_thresh)))) begin
                            r_reached <= 1'b1;
                            r_fin     <= 1'b1;
                            r_cause   <= CAUSE_REACHED;
                            r_sdrv    <= r_stop;
                            r_running <= 1'b0;
                        end
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_vx      <= r_vx;
                        r_o_vy      <= r_vy;
                        r_o_vrot    <= (r_act == ACT_UPDATE && r_running) ||
                                       (r_act == ACT_UPDATE && r_cause == CAUSE_REACHED)
                                       ? vel_rot : '0;
                        r_o_fin     <= r_fin;
                        r_o_cause   <= r_cause;
                        r_o_sdrv    <= r_sdrv;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_vel_x        = r_o_vx;
    assign o_vel_y        = r_o_vy;
    assign o_vel_rot      = r_o_vrot;
    assign o_finished     = r_o_fin;
    assign o_finish_cause = r_o_cause;
    assign o_stop_drive   = r_o_sdrv;

    a_cause_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_finished == (o_finish_cause != CAUSE_NONE)))
        else $error("finish flag and cause disagree");

    a_stop_needs_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stop_drive) |-> o_finished)
        else $error("drive stop without finish");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_no_run_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && r_fin) |-> !r_running)
        else $error("finished item left the maneuver running");

endmodule

/* tb/drive_to_relative_point_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_to_relative_point_checker
// Watches the input and result channels of the maneuver controller, keeps its
// own copy of goal, latches and tick count, predicts each result and compares
// it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module drive_to_relative_point_checker import dtrp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CIDX_W-1:0]    i_cfg_idx,
    input  logic [CDAT_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_action,
    input  logic [31:0]          i_pos_x,
    input  logic [31:0]          i_pos_y,
    input  logic [31:0]          i_yaw,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [OUT_W-1:0]     i_vel_x,
    input  logic [OUT_W-1:0]     i_vel_y,
    input  logic [OUT_W-1:0]     i_vel_rot,
    input  logic                 i_finished,
    input  logic [1:0]           i_finish_cause,
    input  logic                 i_stop_drive,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_reached,
    output int                   o_timeouts
);

    typedef struct packed {
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic [15:0] vel_rot;
        logic        finished;
        logic [1:0]  cause;
        logic        stop;
    } t_command;

    t_command command_q[$];

    logic signed [63:0] off_x, off_y, hdg;
    logic [14:0]        speed;
    logic [15:0]        thresh;
    logic [23:0]        tmo;
    logic               stop_end;
    logic signed [63:0] goal_x, goal_y;
    logic               reached, active;
    logic [23:0]        ticks;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [15:0] apply_sign(input logic [63:0] m, input logic neg);
        logic [63:0] t;
        t = neg ? -m : m;
        return t[15:0];
    endfunction

    task automatic predict_command(input logic [1:0] act, input logic signed [31:0] px,
                                   input logic signed [31:0] py,
                                   input logic signed [31:0] yw);
        t_command c;
        logic signed [63:0] gx, gy, dx, dy, err;
        logic [63:0] ax, ay, big, r, em, vr, rmax;
        int s;
        c = '0;
        if (act == ACT_START) begin
            gx = px + off_x;
            gy = py + off_y;
            goal_x = gx > 64'sd2147483647 ? 64'sd2147483647 :
                     (gx < -64'sd2147483648 ? -64'sd2147483648 : gx);
            goal_y = gy > 64'sd2147483647 ? 64'sd2147483647 :
                     (gy < -64'sd2147483648 ? -64'sd2147483648 : gy);
            reached = 0;
            ticks = 0;
            active = 1;
        end else if (act == ACT_UPDATE && active) begin
            dx = goal_x - px;
            dy = goal_y - py;
            ax = abs64(dx);
            ay = abs64(dy);
            big = ax > ay ? ax : ay;
            s = 0;
            while ((big >> s) >= (64'd1 << 31)) s++;
            ax = ax >> s;
            ay = ay >> s;
            r = root64(ax * ax + ay * ay);
            if (r != 0) begin
                c.vel_x = apply_sign((64'(speed) * ax) / r, dx < 0);
                c.vel_y = apply_sign((64'(speed) * ay) / r, dy < 0);
            end
            if (s == 0 && r <= 64'(thresh)) reached = 1;
            err = hdg - yw;
            em = abs64(err);
            rmax = (64'd3 << 15) / 4;
            vr = (em << 15) / 5120;
            if (vr > rmax) vr = rmax;
            c.vel_rot = apply_sign(vr, err < 0);
            if (reached) begin
                c.finished = 1;
                c.cause = CAUSE_REACHED;
                c.stop = stop_end;
                active = 0;
            end
        end else if (act == ACT_TICK && active) begin
            if (ticks != 24'hFFFFFF) ticks++;
            if (tmo != 0 && ticks >= tmo) begin
                c.finished = 1;
                c.cause = CAUSE_TIMEOUT;
                c.stop = stop_end;
                active = 0;
            end
        end
        command_q.push_back(c);
    endtask

    always @(posedge i_clk) begin
        t_command e, a;
        if (!i_rst_n) begin
            off_x = 0; off_y = 0; hdg = 0; speed = 0; thresh = 256; tmo = 0;
            stop_end = 0; goal_x = 0; goal_y = 0; reached = 0; active = 0; ticks = 0;
            command_q.delete();
            o_errors <= 0;
            o_results <= 0;
            o_reached <= 0;
            o_timeouts <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_OFFSET_X:  off_x = $signed(i_cfg_wdata);
                    REG_OFFSET_Y:  off_y = $signed(i_cfg_wdata);
                    REG_TGT_HDG:   hdg = $signed(i_cfg_wdata);
                    REG_SPEED:     speed = i_cfg_wdata[14:0];
                    REG_THRESHOLD: thresh = i_cfg_wdata[15:0];
                    REG_TIMEOUT:   tmo = i_cfg_wdata[23:0];
                    REG_STOP:      stop_end = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                a = '{i_vel_x, i_vel_y, i_vel_rot, i_finished, i_finish_cause,
                      i_stop_drive};
                o_results <= o_results + 1;
                if (a.cause == CAUSE_REACHED) o_reached <= o_reached + 1;
                if (a.cause == CAUSE_TIMEOUT) o_timeouts <= o_timeouts + 1;
                if (command_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, a);
                    o_errors <= o_errors + 1;
                end else begin
                    e = command_q.pop_front();
                    if (e != a) begin
                        $display("%0t: mismatch expected vx=%h vy=%h vr=%h f=%b c=%0d s=%b",
                                 $time, e.vel_x, e.vel_y, e.vel_rot, e.finished,
                                 e.cause, e.stop);
                        $display("%0t:          actual   vx=%h vy=%h vr=%h f=%b c=%0d s=%b",
                                 $time, a.vel_x, a.vel_y, a.vel_rot, a.finished,
                                 a.cause, a.stop);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_command(i_action, i_pos_x, i_pos_y, i_yaw);
        end
        o_pending <= command_q.size();
    end

endmodule

/* tb/drive_to_relative_point_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_to_relative_point_test
// Runs the maneuver controller through directed corner cases and random
// maneuvers under several settings and idle patterns; a checker compares
// every result with its own prediction.
// ----------------------------------------------------------------------------
module drive_to_relative_point_test;
    import dtrp_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [CIDX_W-1:0]  i_cfg_idx = '0;
    logic [CDAT_W-1:0]  i_cfg_wdata = '0;
    logic               i_in_valid = 0;
    logic               o_in_ready;
    logic [1:0]         i_action = '0;
    logic [31:0]        i_pos_x = '0, i_pos_y = '0, i_yaw = '0;
    logic               o_out_valid;
    logic               i_out_ready = 0;
    logic [OUT_W-1:0]   o_vel_x, o_vel_y, o_vel_rot;
    logic               o_finished, o_stop_drive;
    logic [1:0]         o_finish_cause;
    int                 errors, pending, results, reached_n, timeouts;
    int                 send_idle = 0, recv_idle = 0;
    bit                 hold_off = 0;
    longint             cycles = 0;
    logic signed [31:0] pos_x, pos_y;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    drive_to_relative_point dut (.*);

    drive_to_relative_point_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid, .i_in_ready(o_in_ready), .i_action, .i_pos_x, .i_pos_y, .i_yaw,
        .i_out_valid(o_out_valid), .i_out_ready, .i_vel_x(o_vel_x),
        .i_vel_y(o_vel_y), .i_vel_rot(o_vel_rot), .i_finished(o_finished),
        .i_finish_cause(o_finish_cause), .i_stop_drive(o_stop_drive),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_reached(reached_n), .o_timeouts(timeouts)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain;
        while (pending != 0 || o_out_valid || i_in_valid) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic send_item(input logic [1:0] act, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] yw);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        i_in_valid <= 1;
        i_action <= act;
        i_pos_x <= px;
        i_pos_y <= py;
        i_yaw <= yw;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        i_in_valid <= 0;
    endtask

    function automatic logic [31:0] rand_word;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(4000) - 2000;
            2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: return $urandom_range(1 << 20) - (1 << 19);
        endcase
    endfunction

    task automatic random_config(input bit extreme);
        write_reg(REG_OFFSET_X, extreme ? 32'h7FFF_FFFF : $urandom_range(20000) - 10000);
        write_reg(REG_OFFSET_Y, extreme ? 32'h8000_0000 : $urandom_range(20000) - 10000);
        write_reg(REG_TGT_HDG, $urandom_range(1) ? rand_word() : $urandom_range(20000) - 10000);
        write_reg(REG_SPEED, extreme ? 32'h7FFF : $urandom_range(32767));
        write_reg(REG_THRESHOLD, extreme ? 32'hFFFF : $urandom_range(3000));
        write_reg(REG_TIMEOUT, $urandom_range(2) == 0 ? 0 : $urandom_range(1, 12));
        write_reg(REG_STOP, $urandom_range(1));
    endtask

    // One maneuver: a start, then updates that move the position in small steps
    // with ticks mixed in, and a little noise.
    task automatic maneuver(input int len);
        logic signed [31:0] sx, sy;
        int k;
        sx = $urandom_range(200000) - 100000;
        sy = $urandom_range(200000) - 100000;
        pos_x = sx;
        pos_y = sy;
        send_item(ACT_START, sx, sy, rand_word());
        for (k = 0; k < len; k++) begin
            case ($urandom_range(9))
                0, 1: send_item(ACT_TICK, rand_word(), rand_word(), rand_word());
                2: send_item(2'd3, rand_word(), rand_word(), rand_word());
                3: send_item(ACT_UPDATE, rand_word(), rand_word(), rand_word());
                default: begin
                    pos_x = pos_x + ($urandom_range(4000) - 1000);
                    pos_y = pos_y + ($urandom_range(4000) - 1000);
                    send_item(ACT_UPDATE, pos_x, pos_y, $urandom_range(40000) - 20000);
                end
            endcase
        end
    endtask

    initial begin
        int ph, n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed corner cases.
        send_item(ACT_UPDATE, 0, 0, 0);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        random_config(1);
        write_reg(REG_TGT_HDG, 32'h7FFF_FFFF);
        write_reg(REG_TIMEOUT, 32'hFF_FFFF);
        send_item(ACT_START, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_item(ACT_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(ACT_TICK, 0, 0, 0);
        drain();
        write_reg(REG_OFFSET_X, 0);
        write_reg(REG_OFFSET_Y, 0);
        write_reg(REG_TGT_HDG, 32'h8000_0000);
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_SPEED, 0);
        write_reg(REG_TIMEOUT, 2);
        send_item(ACT_START, 1000, -1000, 0);
        send_item(ACT_UPDATE, 1000, -1000, 5);
        send_item(ACT_START, 1000, -1000, 0);
        send_item(ACT_UPDATE, 1100, -900, -5);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_TICK, 0, 0, 0);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_idle <= 0;  end
                1: begin send_idle = 49; recv_idle <= 0;  end
                2: begin send_idle = 0;  recv_idle <= 49; end
                default: begin send_idle = 22; recv_idle <= 22; end
            endcase
            random_config(ph == 4);
            n = 0;
            while (n < 135) begin
                maneuver(15);
                n += 16;
            end
            if (ph == 2) begin
                hold_off <= 1;
                fork
                    begin
                        repeat (400) @(posedge i_clk);
                        hold_off <= 0;
                    end
                    maneuver(6);
                join
            end
            drain();
        end

        $display("Ran %0d results: %0d finished close enough, %0d by timeout.",
                 results, reached_n, timeouts);
        $display("Covered register extremes, idle and reset-time items, and four idle mixes.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* drive_to_relative_point.f */
rtl/dtrp_pkg.sv
rtl/dtrp_sqrt.sv
rtl/dtrp_div.sv
rtl/dtrp_rot.sv
rtl/drive_to_relative_point.sv
tb/drive_to_relative_point_checker.sv
tb/drive_to_relative_point_test.sv
